// ===== sv/midpoint_line_rasterizer_top_assert.svh =====
// Assertion macros for the midpoint line rasterizer
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mlr_pkg.sv =====
// Types and constants shared by the midpoint line rasterizer modules
package mlr_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned DecBits   = CoordBits + 3;
  localparam int unsigned ColorBits = 32;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] span_t;
  typedef logic signed [DecBits-1:0]   dec_t;
  typedef logic        [ColorBits-1:0] color_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    op_e    op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t color;
    logic   last;
  } out_word_t;

endpackage

// ===== sv/mlr_core.sv =====
// Line set-up and per-pixel midpoint stepping with the colour register
module mlr_core import mlr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  color_t    cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      hold_i,
  input  in_word_t  in_word_i,
  output logic      res_valid_o,
  output out_word_t res_word_o,
  output logic      active_o
);

  color_t color_q;
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  coord_t major_end_q, major_end_d;
  dec_t   decision_q, decision_d;
  dec_t   inc_straight_q, inc_straight_d;
  dec_t   inc_diagonal_q, inc_diagonal_d;
  logic   y_down_q, y_down_d;
  logic   steep_q, steep_d;
  logic   active_q, active_d;

  logic             accept;
  logic             swap;
  coord_t           x0, y0, x1, y1;
  logic [CoordBits:0] dx_w, dy_w;
  span_t            dx, dy, dmaj, dmin;
  logic             y_desc, is_steep;
  dec_t             dmaj_w, dmin_w;
  coord_t           major;
  logic             is_last;
  logic             go_diag;
  coord_t           y_next;

  assign accept = in_valid_i & ~hold_i;

  // set-up: order endpoints by x, pick major axis and y direction
  always_comb begin
    swap = ~(in_word_i.x_end > in_word_i.x_start);
    x0   = swap ? in_word_i.x_end   : in_word_i.x_start;
    y0   = swap ? in_word_i.y_end   : in_word_i.y_start;
    x1   = swap ? in_word_i.x_start : in_word_i.x_end;
    y1   = swap ? in_word_i.y_start : in_word_i.y_end;
    y_desc = y1 < y0;
    dx_w = {x1[CoordBits-1], x1} - {x0[CoordBits-1], x0};
    dy_w = y_desc ? ({y0[CoordBits-1], y0} - {y1[CoordBits-1], y1})
                  : ({y1[CoordBits-1], y1} - {y0[CoordBits-1], y0});
    dx   = dx_w[CoordBits-1:0];
    dy   = dy_w[CoordBits-1:0];
    is_steep = dy > dx;
    dmaj = is_steep ? dy : dx;
    dmin = is_steep ? dx : dy;
    dmaj_w = {{(DecBits-CoordBits){1'b0}}, dmaj};
    dmin_w = {{(DecBits-CoordBits){1'b0}}, dmin};
  end

  // per-pixel step
  always_comb begin
    major   = steep_q ? cur_y_q : cur_x_q;
    is_last = major == major_end_q;
    go_diag = ~decision_q[DecBits-1] & (|decision_q);
    y_next  = y_down_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
  end

  always_comb begin
    cur_x_d        = cur_x_q;
    cur_y_d        = cur_y_q;
    major_end_d    = major_end_q;
    decision_d     = decision_q;
    inc_straight_d = inc_straight_q;
    inc_diagonal_d = inc_diagonal_q;
    y_down_d       = y_down_q;
    steep_d        = steep_q;
    active_d       = active_q;
    if (accept) begin
      if (in_word_i.op == OP_START) begin
        cur_x_d        = x0;
        cur_y_d        = y0;
        major_end_d    = is_steep ? y1 : x1;
        decision_d     = (dmin_w <<< 1) - dmaj_w;
        inc_straight_d = dmin_w <<< 1;
        inc_diagonal_d = (dmin_w - dmaj_w) <<< 1;
        y_down_d       = y_desc;
        steep_d        = is_steep;
        active_d       = 1'b1;
      end else if (active_q) begin
        if (is_last) begin
          active_d = 1'b0;
        end else begin
          decision_d = decision_q + (go_diag ? inc_diagonal_q : inc_straight_q);
          if (steep_q) begin
            cur_y_d = y_next;
            if (go_diag) begin
              cur_x_d = cur_x_q + coord_t'(1);
            end
          end else begin
            cur_x_d = cur_x_q + coord_t'(1);
            if (go_diag) begin
              cur_y_d = y_next;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q        <= '0;
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      major_end_q    <= '0;
      decision_q     <= '0;
      inc_straight_q <= '0;
      inc_diagonal_q <= '0;
      y_down_q       <= 1'b0;
      steep_q        <= 1'b0;
      active_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      cur_x_q        <= cur_x_d;
      cur_y_q        <= cur_y_d;
      major_end_q    <= major_end_d;
      decision_q     <= decision_d;
      inc_straight_q <= inc_straight_d;
      inc_diagonal_q <= inc_diagonal_d;
      y_down_q       <= y_down_d;
      steep_q        <= steep_d;
      active_q       <= active_d;
    end
  end

  assign res_valid_o        = accept & (in_word_i.op == OP_TICK) & active_q;
  assign res_word_o.pixel_x = cur_x_q;
  assign res_word_o.pixel_y = cur_y_q;
  assign res_word_o.color   = color_q;
  assign res_word_o.last    = is_last;
  assign active_o           = active_q;

endmodule

// ===== sv/mlr_skid.sv =====
// Output register with one skid entry for the pixel channel
module mlr_skid import mlr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t push_word_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic      out_valid_q, skid_valid_q;
  out_word_t out_q, skid_q;
  logic      out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload: drain skid first, else take the new word
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : push_word_i;
    end else if (push_i) begin
      skid_q <= push_word_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/midpoint_line_rasterizer_top.sv =====
// Top level of the midpoint line rasterizer
//
// Input channel (in_valid_i / in_stall_o / in_word_i): a start word latches two
// endpoints and sets up the line; it gives no pixel. Each tick word then gives
// one pixel, from the endpoint of smaller x to the other (from the second if
// both x are equal), with the final one flagged last, after which ticks give
// nothing until the next start. A start abandons any line in progress.
// Output channel (out_valid_o / out_stall_i / out_word_o): one word per pixel.
// Configuration: cfg_we_i writes cfg_wdata_i as the pixel colour; write only
// while idle.
// Output: an accepted tick's pixel goes into the output register, or the skid entry.
// Throughput: one word per cycle on both sides while no stall is raised; the
// major-axis compare sits between the line registers and the output register.
// Stall: the output register holds while out_stall_i is high and one further
// pixel parks in a skid entry; in_stall_o rises while that entry is occupied.
// Reset: the block comes up idle, colour zero, both channels empty.
module midpoint_line_rasterizer_top import mlr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  color_t    cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

`include "midpoint_line_rasterizer_top_assert.svh"

  logic      res_valid;
  out_word_t res_word;
  logic      skid_full;
  logic      core_active;

  mlr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .hold_i      (skid_full),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .active_o    (core_active)
  );

  mlr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_word_i (res_word),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = skid_full;

  `MLR_ASSERT_NOW(a_no_push_when_full, res_valid, !skid_full, "pixel pushed into full skid")
  `MLR_ASSERT_NEXT(a_last_ends_line, res_valid && res_word.last, !core_active, "line active after last")
  `MLR_ASSERT_NEXT(a_full_holds, skid_full && out_stall_i, skid_full && out_valid_o, "skid lost word")
  `MLR_ASSERT_NOW(a_start_no_pixel, in_valid_i && in_word_i.op == OP_START, !res_valid, "pixel on start")

endmodule

// ===== tb/sv/midpoint_line_rasterizer_top_test.sv =====
// Self-checking testbench for the midpoint line rasterizer with its own pixel predictor
module midpoint_line_rasterizer_top_test import mlr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PhaseWords = 100;
  localparam int unsigned HoldCycles = 60;

  class pixel_tracker;
    color_t      colour;
    coord_t      cur_x;
    coord_t      cur_y;
    coord_t      major_end;
    dec_t        decision;
    dec_t        inc_straight;
    dec_t        inc_diagonal;
    bit          y_down;
    bit          steep;
    bit          line_open;
    out_word_t   pending[$];
    int unsigned mismatches;

    function new();
      colour       = '0;
      cur_x        = '0;
      cur_y        = '0;
      major_end    = '0;
      decision     = '0;
      inc_straight = '0;
      inc_diagonal = '0;
      y_down       = 1'b0;
      steep        = 1'b0;
      line_open    = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_colour(color_t c);
      colour = c;
    endfunction

    function void take_word(in_word_t w);
      int xa, ya, xb, yb, x0, y0, x1, y1, dx, dy, dmaj, dmin, major;
      bit        at_end;
      out_word_t p;
      if (w.op == OP_START) begin
        xa = w.x_start;
        ya = w.y_start;
        xb = w.x_end;
        yb = w.y_end;
        if (xb > xa) begin
          x0 = xa; y0 = ya; x1 = xb; y1 = yb;
        end else begin
          x0 = xb; y0 = yb; x1 = xa; y1 = ya;
        end
        dx = x1 - x0;
        y_down = (y1 < y0);
        dy = y_down ? (y0 - y1) : (y1 - y0);
        steep = (dy > dx);
        dmaj = steep ? dy : dx;
        dmin = steep ? dx : dy;
        decision     = dec_t'(2 * dmin - dmaj);
        inc_straight = dec_t'(2 * dmin);
        inc_diagonal = dec_t'(2 * (dmin - dmaj));
        major_end    = coord_t'(steep ? y1 : x1);
        cur_x        = coord_t'(x0);
        cur_y        = coord_t'(y0);
        line_open    = 1'b1;
        return;
      end
      if (!line_open) return;
      major  = steep ? cur_y : cur_x;
      at_end = (major == int'(major_end));
      p.pixel_x = cur_x;
      p.pixel_y = cur_y;
      p.color   = colour;
      p.last    = at_end;
      pending.insert(pending.size(), p);
      if (at_end) begin
        line_open = 1'b0;
        return;
      end
      if (steep) begin
        if (decision > 0) begin
          cur_x    = coord_t'(cur_x + 1);
          decision = decision + inc_diagonal;
        end else begin
          decision = decision + inc_straight;
        end
        cur_y = y_down ? coord_t'(cur_y - 1) : coord_t'(cur_y + 1);
      end else begin
        if (decision > 0) begin
          cur_y    = y_down ? coord_t'(cur_y - 1) : coord_t'(cur_y + 1);
          decision = decision + inc_diagonal;
        end else begin
          decision = decision + inc_straight;
        end
        cur_x = coord_t'(cur_x + 1);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_pixel(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.pixel_x, got.pixel_y));
        return;
      end
      want = pending.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report_mismatch($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report_mismatch($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
      if (got.color !== want.color)
        report_mismatch($sformatf("color got %h want %h", got.color, want.color));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b want %b at (%0d,%0d)", got.last, want.last,
                                  want.pixel_x, want.pixel_y));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  color_t    cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  pixel_tracker tracker = new();

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_go    = 1'b0;
  bit          hold_used  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned quiet      = 0;

  midpoint_line_rasterizer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_word(in_word);
      if (out_valid && !out_stall) tracker.check_pixel(out_word);
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles - 1;
      hold_used <= 1'b1;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic in_word_t tick_word();
    in_word_t w;
    w.op      = OP_TICK;
    w.x_start = coord_t'($urandom);
    w.y_start = coord_t'($urandom);
    w.x_end   = coord_t'($urandom);
    w.y_end   = coord_t'($urandom);
    return w;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  task automatic send_word(in_word_t w);
    while (tx_idle_on && ($urandom_range(0, 99) < 14)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line(int xs, int ys, int xe, int ye, int ticks);
    in_word_t w;
    w.op      = OP_START;
    w.x_start = coord_t'(xs);
    w.y_start = coord_t'(ys);
    w.x_end   = coord_t'(xe);
    w.y_end   = coord_t'(ye);
    send_word(w);
    repeat (ticks) send_word(tick_word());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_colour(color_t c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_colour(c);
  endtask

  task automatic run_lines(int quota);
    int count, xs, ys, xe, ye, span, adx, ady, pixels, ticks;
    bit dangling;
    count    = 0;
    dangling = 1'b0;
    while (count < quota || dangling) begin
      span = ($urandom_range(0, 99) < 6) ? 200 : 12;
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      xe = clamp_coord(xs + int'($urandom_range(0, 2 * span)) - span);
      ye = clamp_coord(ys + int'($urandom_range(0, 2 * span)) - span);
      adx = (xe > xs) ? xe - xs : xs - xe;
      ady = (ye > ys) ? ye - ys : ys - ye;
      pixels = ((adx > ady) ? adx : ady) + 1;
      dangling = ($urandom_range(0, 99) < 8);
      ticks = dangling ? int'($urandom_range(0, pixels - 1)) : pixels;
      send_line(xs, ys, xe, ye, ticks);
      count += 1 + ticks;
      if (!dangling && ($urandom_range(0, 99) < 5)) send_word(tick_word());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_colour(32'hA5C3_5A3C);

    send_word(tick_word());
    send_line(5, -7, 5, -7, 1);
    send_word(tick_word());
    send_line(-2048, 2047, 2047, -2048, 2);
    send_line(2047, -2048, -2048, 2047, 1);
    send_line(3, 2, 3, 0, 3);
    send_line(0, 0, 4, -2, 5);
    send_line(0, 0, 1, -3, 4);
    drain();

    write_colour(32'h0000_0000);
    run_lines(PhaseWords);
    drain();

    write_colour(32'hFFFF_FFFF);
    hold_go = 1'b1;
    send_line(-100, 50, 60, -20, 161);
    run_lines(PhaseWords);
    drain();

    write_colour($urandom);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_lines(PhaseWords);
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    write_colour(32'h8000_0001);
    run_lines(PhaseWords);
    drain();

    write_colour($urandom);
    run_lines(PhaseWords);
    drain();

    if (tracker.pending.size() != 0)
      tracker.report_mismatch($sformatf("%0d pixels never arrived", tracker.pending.size()));
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
